// ----- design/assert_macros.svh -----
// Assertion helpers; both expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ISFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ISFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ISFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ISFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/isfp_pkg.sv -----
`default_nettype none
package isfp_pkg;

  localparam int RX_W     = 8;
  localparam int RAW_W    = 16;
  localparam int SCALED_W = 25;
  localparam int FACTOR_W = 10;
  localparam int CNT_W    = 3;
  localparam int HOLD_N   = 4;

  localparam int ISFP_QUEUE_DEPTH = 2;

  localparam logic [RX_W-1:0] HDR_BYTE   = 8'h5A;
  localparam logic [RX_W-1:0] TYPE_RATE  = 8'hAA;
  localparam logic [RX_W-1:0] TYPE_ANGLE = 8'hBB;

  localparam logic [CNT_W-1:0] CHK_POS = 3'd4;

  localparam logic [FACTOR_W-1:0] RATE_FACTOR  = 10'd500;
  localparam logic [FACTOR_W-1:0] ANGLE_FACTOR = 10'd45;

  localparam logic KIND_RATE  = 1'b0;
  localparam logic KIND_ANGLE = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [RAW_W-1:0] raw;
  } frame_entry_t;

  typedef struct packed {
    logic         push;
    frame_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic         valid;
    logic         full;
    frame_entry_t entry;
  } q_status_t;

endpackage
`default_nettype wire

// ----- design/isfp_channels.sv -----
`default_nettype none
interface isfp_in_if import isfp_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [RX_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface isfp_out_if import isfp_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic                       frame_kind;
  logic signed [RAW_W-1:0]    raw_value;
  logic signed [SCALED_W-1:0] scaled_value;

  modport source (output valid, output frame_kind, output raw_value,
                  output scaled_value, input ready);
  modport sink   (input valid, input frame_kind, input raw_value,
                  input scaled_value, output ready);
endinterface
`default_nettype wire

// ----- design/imu_serial_frame_parser_top.sv -----
// A good frame's result is queued at its checksum byte and registered for output.
// Throughput: one byte per cycle unless stalled; at most one result per five bytes.
// The front stalls only while the result queue (QUEUE_DEPTH entries) is full.
// The scaling multiply is in the back stage; one product per cycle unless stalled.
// Reset (rst_n low, synchronous) empties the queue and output and restarts framing.
`default_nettype none
`include "assert_macros.svh"
module imu_serial_frame_parser_top import isfp_pkg::*; #(
  parameter int QUEUE_DEPTH = ISFP_QUEUE_DEPTH
) (
  input wire logic   clk,
  input wire logic   rst_n,
  isfp_in_if.sink    in_ch,
  isfp_out_if.source out_ch
);

  q_push_t   q_push;
  q_status_t q_stat;
  logic      q_pop;

  isfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full_i (q_stat.full),
    .push_o   (q_push)
  );

  isfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (q_push),
    .pop_i  (q_pop),
    .stat_o (q_stat)
  );

  isfp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_i    (q_stat),
    .pop_o  (q_pop),
    .out_ch (out_ch)
  );

  `ISFP_ASSERT(a_no_push_full, clk, rst_n, !(q_push.push && q_stat.full), "push into full queue")
  `ISFP_ASSERT(a_stall_only_full, clk, rst_n, in_ch.ready || q_stat.full, "input stalled with room")
  `ISFP_ASSERT_NEXT(a_pop_shows, clk, rst_n, q_pop, out_ch.valid, "popped item not presented")

endmodule
`default_nettype wire

// ----- design/isfp_queue.sv -----
`default_nettype none
module isfp_queue import isfp_pkg::*; #(
  parameter int DEPTH = ISFP_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_push_t   push_i,
  input  wire logic      pop_i,
  output q_status_t      stat_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  frame_entry_t  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          full, empty, do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push_i.push && !full;
  assign do_pop  = pop_i && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_i.entry;
  end

  assign stat_o.valid = !empty;
  assign stat_o.full  = full;
  assign stat_o.entry = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

// ----- design/isfp_front.sv -----
`default_nettype none
module isfp_front import isfp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  isfp_in_if.sink    in_ch,
  input  wire logic  q_full_i,
  output q_push_t    push_o
);

  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [RX_W-1:0]  frame_r [HOLD_N];
  logic [RX_W-1:0]  sum;
  logic             acc, at_chk, known;

  assign in_ch.ready = !q_full_i;
  assign acc         = in_ch.valid && in_ch.ready;
  assign at_chk      = (byte_cnt_r >= CHK_POS);

  assign sum   = frame_r[0] + frame_r[1] + frame_r[2] + frame_r[3];
  assign known = (frame_r[1] == TYPE_RATE) || (frame_r[1] == TYPE_ANGLE);

  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    if (acc) begin
      if (at_chk) begin
        byte_cnt_nxt = '0;
      end else if (byte_cnt_r != '0 || in_ch.rx_byte == HDR_BYTE) begin
        byte_cnt_nxt = byte_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
    end else begin
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

  // drop a stray first byte; hold every other byte but the checksum at its frame slot
  always_ff @(posedge clk) begin
    if (acc && !at_chk && (byte_cnt_r != '0 || in_ch.rx_byte == HDR_BYTE)) begin
      frame_r[byte_cnt_r[1:0]] <= in_ch.rx_byte;
    end
  end

  assign push_o.push       = acc && at_chk && (sum == in_ch.rx_byte) && known;
  assign push_o.entry.kind = (frame_r[1] == TYPE_ANGLE) ? KIND_ANGLE : KIND_RATE;
  assign push_o.entry.raw  = {frame_r[3], frame_r[2]};

endmodule
`default_nettype wire

// ----- design/isfp_back.sv -----
`default_nettype none
module isfp_back import isfp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_status_t q_i,
  output logic           pop_o,
  isfp_out_if.source     out_ch
);

  logic                       out_valid_r, out_valid_nxt;
  logic                       kind_r;
  logic signed [RAW_W-1:0]    raw_r;
  logic signed [SCALED_W-1:0] scaled_r;
  logic [FACTOR_W-1:0]        factor;
  logic signed [SCALED_W-1:0] raw_ext, fac_ext, product;

  assign pop_o = q_i.valid && (!out_valid_r || out_ch.ready);

  assign factor  = (q_i.entry.kind == KIND_ANGLE) ? ANGLE_FACTOR : RATE_FACTOR;
  assign raw_ext = SCALED_W'(q_i.entry.raw);
  assign fac_ext = SCALED_W'(signed'({1'b0, factor}));
  assign product = raw_ext * fac_ext;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop_o) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      kind_r   <= q_i.entry.kind;
      raw_r    <= q_i.entry.raw;
      scaled_r <= product;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_kind   = kind_r;
  assign out_ch.raw_value    = raw_r;
  assign out_ch.scaled_value = scaled_r;

endmodule
`default_nettype wire
